/* sv/trfp_pkg.sv */
// ----------------------------------------------------------------------------
// trfp_pkg: shared types and constants for the tagged record field parser
// Word layouts, record codes, result kinds and the parse phase encoding.
// ----------------------------------------------------------------------------
package trfp_pkg;

    // Input word: one blob byte with its end flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    // Output word: one parser event
    typedef struct packed {
        logic [1:0]  event_kind;
        logic [7:0]  char_byte;
        logic [1:0]  field_type;
        logic [63:0] field_value;
        logic        run_last;
    } out_word_t;

    // Event kinds
    localparam logic [1:0] EV_KEY    = 2'd0;
    localparam logic [1:0] EV_STRING = 2'd1;
    localparam logic [1:0] EV_COMMIT = 2'd2;
    localparam logic [1:0] EV_DROP   = 2'd3;

    // Committed field types
    localparam logic [1:0] FT_NUMBER  = 2'd0;
    localparam logic [1:0] FT_INTEGER = 2'd1;
    localparam logic [1:0] FT_STRING  = 2'd2;
    localparam logic [1:0] FT_BOOLEAN = 2'd3;

    // Byte codes of the record format
    localparam logic [7:0] BYTE_NUL      = 8'h00;
    localparam logic [7:0] BYTE_TAG      = 8'h01;
    localparam logic [7:0] SIZE_NUMBER   = 8'h09;
    localparam logic [7:0] SIZE_INTEGER  = 8'h05;
    localparam logic [7:0] SIZE_BOOLEAN  = 8'h01;
    localparam logic [7:0] TYPE_NUMBER   = 8'h04;
    localparam logic [7:0] TYPE_INTEGER  = 8'h01;
    localparam logic [7:0] TYPE_STRING   = 8'h05;
    localparam logic [7:0] TYPE_BOOL_T   = 8'h02;
    localparam logic [7:0] TYPE_BOOL_F   = 8'h03;
    localparam logic [7:0] KEY_CHAR_MIN  = 8'd32;
    localparam logic [7:0] KEY_CHAR_MAX  = 8'd126;
    localparam logic [7:0] NUMBER_BYTES  = 8'd8;
    localparam logic [7:0] INTEGER_BYTES = 8'd4;

    // Result queue depth
    localparam int OUT_DEPTH = 4;

    // Parse phase, one-hot
    typedef enum logic [6:0] {
        PH_HEADER  = 7'b0000001,
        PH_KEY     = 7'b0000010,
        PH_TAG     = 7'b0000100,
        PH_SIZE    = 7'b0001000,
        PH_TYPE    = 7'b0010000,
        PH_PAYLOAD = 7'b0100000,
        PH_IGNORE  = 7'b1000000
    } phase_t;

    // Per-record working state
    typedef struct packed {
        logic        key_seen;
        logic        key_bad;
        logic [7:0]  size_byte;
        logic [7:0]  kind_byte;
        logic [7:0]  payload_count;
        logic [63:0] value_shift;
        logic        string_ended;
        logic [7:0]  string_length;
    } rec_t;

    // Build an event word with run_last clear
    function automatic out_word_t mk_event(
        input logic [1:0]  kind,
        input logic [7:0]  ch,
        input logic [1:0]  ftype,
        input logic [63:0] val
    );
        out_word_t w;
        w.event_kind  = kind;
        w.char_byte   = ch;
        w.field_type  = ftype;
        w.field_value = val;
        w.run_last    = 1'b0;
        return w;
    endfunction

endpackage

/* sv/tagged_record_field_parser.sv */
// ----------------------------------------------------------------------------
// tagged_record_field_parser: streaming parser for tagged scalar records
// Skips the header name, streams key and string bytes, and closes each
// record with a commit or drop event.
// ----------------------------------------------------------------------------
// One blob byte is taken per cycle while s_ready is high. Each byte is decoded
// in the cycle it is accepted against the parse state registers, and the zero,
// one or two events it causes are written into a four-word result queue, which
// registers them before they reach the m_ side. Events leave at one per cycle
// while m_ready is high, so the input sustains one byte per cycle while bytes
// cause at most one event each; a byte that causes two events (a bad tag byte
// followed by a new key byte or empty key, a string byte followed by its
// commit, or a result followed by the end-of-blob drop) takes two queue words,
// and s_ready falls whenever fewer than two queue words are free.
module tagged_record_field_parser
    import trfp_pkg::*;
#(
    parameter int Depth = OUT_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    // State and queue registers
    phase_t             phase_reg, phase_next;
    rec_t               rec_reg, rec_next;
    out_word_t          fifo_reg [Depth];
    logic [PtrW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]    count_reg, count_next;

    // Decode results
    out_word_t          res0, res1;
    logic [1:0]         n_res;
    logic               handled_end;
    logic               pending;
    logic               accept, pop;
    logic [7:0]         b;
    logic               last;
    logic               nonprint;
    logic [7:0]         cnt_dec;
    logic [2:0]         lane;
    logic [5:0]         shamt;
    logic [63:0]        val_acc;
    logic [7:0]         len_inc;
    logic [1:0]         push;

    assign b        = s_data.data_byte;
    assign last     = s_data.last_byte;
    assign nonprint = (b < KEY_CHAR_MIN) || (b > KEY_CHAR_MAX);
    assign accept   = s_valid && s_ready;
    assign pop      = m_valid && m_ready;

    // Payload byte placement: lane is the byte index within the value
    assign cnt_dec = rec_reg.payload_count - 8'd1;
    assign lane    = 3'd0 - rec_reg.payload_count[2:0];
    assign shamt   = (rec_reg.kind_byte == TYPE_NUMBER) ? {lane, 3'b000}
                                                        : {1'b0, lane[1:0], 3'b000};
    assign val_acc = rec_reg.value_shift | ({56'd0, b} << shamt);
    assign len_inc = rec_reg.string_length + 8'd1;

    // Byte decode
    always_comb begin
        phase_next  = phase_reg;
        rec_next    = rec_reg;
        res0        = '0;
        res1        = '0;
        n_res       = 2'd0;
        handled_end = 1'b0;
        pending     = 1'b0;

        unique case (phase_reg)
            PH_HEADER: begin
                if (b == BYTE_NUL) begin
                    rec_next   = '0;
                    phase_next = PH_KEY;
                end
            end
            PH_KEY: begin
                if (b == BYTE_NUL) begin
                    if (!rec_reg.key_seen || rec_reg.key_bad) begin
                        res0       = mk_event(EV_DROP, 8'd0, 2'd0, 64'd0);
                        n_res      = 2'd1;
                        rec_next   = '0;
                        phase_next = PH_KEY;
                    end else begin
                        rec_next.key_seen = 1'b0;
                        rec_next.key_bad  = 1'b0;
                        phase_next        = PH_TAG;
                    end
                end else begin
                    res0              = mk_event(EV_KEY, b, 2'd0, 64'd0);
                    n_res             = 2'd1;
                    rec_next.key_seen = 1'b1;
                    rec_next.key_bad  = rec_reg.key_bad | nonprint;
                end
            end
            PH_TAG: begin
                if (b == BYTE_TAG) begin
                    phase_next = PH_SIZE;
                end else begin
                    // missing tag: drop, then this byte opens the next key
                    res0       = mk_event(EV_DROP, 8'd0, 2'd0, 64'd0);
                    n_res      = 2'd1;
                    rec_next   = '0;
                    phase_next = PH_KEY;
                    if (last) begin
                        handled_end = 1'b1;
                    end else if (b == BYTE_NUL) begin
                        res1  = mk_event(EV_DROP, 8'd0, 2'd0, 64'd0);
                        n_res = 2'd2;
                    end else begin
                        res1              = mk_event(EV_KEY, b, 2'd0, 64'd0);
                        n_res             = 2'd2;
                        rec_next.key_seen = 1'b1;
                        rec_next.key_bad  = nonprint;
                    end
                end
            end
            PH_SIZE: begin
                rec_next.size_byte = b;
                phase_next         = PH_TYPE;
            end
            PH_TYPE: begin
                rec_next.kind_byte = b;
                if (rec_reg.size_byte == SIZE_NUMBER && b == TYPE_NUMBER) begin
                    rec_next.payload_count = NUMBER_BYTES;
                    rec_next.value_shift   = 64'd0;
                    phase_next             = PH_PAYLOAD;
                end else if (rec_reg.size_byte == SIZE_INTEGER && b == TYPE_INTEGER) begin
                    rec_next.payload_count = INTEGER_BYTES;
                    rec_next.value_shift   = 64'd0;
                    phase_next             = PH_PAYLOAD;
                end else if (b == TYPE_STRING) begin
                    if (rec_reg.size_byte == 8'd0) begin
                        res0       = mk_event(EV_COMMIT, 8'd0, FT_STRING, 64'd0);
                        n_res      = 2'd1;
                        rec_next   = '0;
                        phase_next = PH_KEY;
                    end else begin
                        rec_next.payload_count = rec_reg.size_byte;
                        rec_next.string_ended  = 1'b0;
                        rec_next.string_length = 8'd0;
                        phase_next             = PH_PAYLOAD;
                    end
                end else if (rec_reg.size_byte == SIZE_BOOLEAN &&
                             (b == TYPE_BOOL_T || b == TYPE_BOOL_F)) begin
                    res0       = mk_event(EV_COMMIT, 8'd0, FT_BOOLEAN,
                                          {63'd0, b == TYPE_BOOL_T});
                    n_res      = 2'd1;
                    rec_next   = '0;
                    phase_next = PH_KEY;
                end else begin
                    // unknown record kind: rest of the blob is ignored
                    res0       = mk_event(EV_DROP, 8'd0, 2'd0, 64'd0);
                    n_res      = 2'd1;
                    rec_next   = '0;
                    phase_next = PH_IGNORE;
                end
            end
            PH_PAYLOAD: begin
                rec_next.payload_count = cnt_dec;
                if (rec_reg.kind_byte == TYPE_STRING) begin
                    if (!rec_reg.string_ended && b == BYTE_NUL) begin
                        rec_next.string_ended = 1'b1;
                    end
                    if (!rec_reg.string_ended && b != BYTE_NUL) begin
                        res0                   = mk_event(EV_STRING, b, 2'd0, 64'd0);
                        n_res                  = 2'd1;
                        rec_next.string_length = len_inc;
                        if (cnt_dec == 8'd0) begin
                            res1  = mk_event(EV_COMMIT, 8'd0, FT_STRING, {56'd0, len_inc});
                            n_res = 2'd2;
                        end
                    end else if (cnt_dec == 8'd0) begin
                        res0  = mk_event(EV_COMMIT, 8'd0, FT_STRING,
                                         {56'd0, rec_reg.string_length});
                        n_res = 2'd1;
                    end
                end else begin
                    rec_next.value_shift = val_acc;
                    if (cnt_dec == 8'd0) begin
                        if (rec_reg.kind_byte == TYPE_NUMBER) begin
                            res0 = mk_event(EV_COMMIT, 8'd0, FT_NUMBER, val_acc);
                        end else begin
                            res0 = mk_event(EV_COMMIT, 8'd0, FT_INTEGER,
                                            {{32{val_acc[31]}}, val_acc[31:0]});
                        end
                        n_res = 2'd1;
                    end
                end
                if (cnt_dec == 8'd0) begin
                    rec_next   = '0;
                    phase_next = PH_KEY;
                end
            end
            PH_IGNORE: begin
            end
            default: begin
                phase_next = PH_HEADER;
            end
        endcase

        // End of blob: close any open record, then back to the header
        if (last) begin
            pending = (phase_next == PH_TAG) || (phase_next == PH_SIZE) ||
                      (phase_next == PH_TYPE) || (phase_next == PH_PAYLOAD) ||
                      (phase_next == PH_KEY && rec_next.key_seen);
            if (pending && !handled_end) begin
                if (n_res == 2'd0) begin
                    res0  = mk_event(EV_DROP, 8'd0, 2'd0, 64'd0);
                    n_res = 2'd1;
                end else if (n_res == 2'd1) begin
                    res1  = mk_event(EV_DROP, 8'd0, 2'd0, 64'd0);
                    n_res = 2'd2;
                end
            end
            phase_next = PH_HEADER;
            rec_next   = '0;
        end

        // Mark the final event of this byte
        if (n_res == 2'd1) begin
            res0.run_last = 1'b1;
        end else if (n_res == 2'd2) begin
            res1.run_last = 1'b1;
        end
    end

    // Parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            rec_reg   <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            rec_reg   <= rec_next;
        end
    end

    // Result queue
    assign push       = accept ? n_res : 2'd0;
    assign count_next = count_reg + CntW'(push) - CntW'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PtrW'(push);
            rd_ptr_reg <= rd_ptr_reg + PtrW'(pop);
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (push == 2'd2) begin
            fifo_reg[wr_ptr_reg + PtrW'(1)] <= res1;
        end
    end

    assign s_ready = (count_reg <= CntW'(Depth - 2));
    assign m_valid = (count_reg != '0);
    assign m_data  = fifo_reg[rd_ptr_reg];

endmodule
